// File: hw/rtl/gpe_pkg.sv
`timescale 1ns / 1ps
package gpe_pkg;

  localparam int MAX_DEGREE_DEF = 32;

  localparam logic signed [63:0] ONE_Q32   = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] ONE_Q16   = 64'sh0000_0000_0001_0000;
  localparam logic signed [63:0] SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN   = 64'sh8000_0000_0000_0000;

  // result scaling of the shared multiplier
  typedef enum logic [1:0] {
    SH_14,
    SH_16,
    SH_32
  } sh_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_ACC,
    M_RND,
    M_FIN
  } mphase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C1,
    ST_XP,
    ST_T1,
    ST_T2,
    ST_DIV,
    ST_SC,
    ST_RES,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic start;
    sh_t  sh;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } mul_rsp_t;

endpackage

// File: hw/rtl/gegenbauer_poly_eval.sv
`timescale 1ns / 1ps
// channel   direction  ports
// in        input      in_valid, in_stall, in_degree, in_order_a, in_point_x, in_deriv_order
// out       output     out_valid, out_stall, out_value, out_overflow
//
// one item at a time; in_stall stays high from acceptance until the result is taken
// multiply step: request, four 32x32 partial products, round, saturate, handoff
// divide step: request, 64 quotient bits produced in groups of 8, handoff
// degree n is clamped to MAX_DEGREE; when k > n the item skips the computation and gives zero
// rst_n is synchronous; a result held on a stalled out channel does not change
module gegenbauer_poly_eval #(
  parameter int MAX_DEGREE = gpe_pkg::MAX_DEGREE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         in_degree,
  input  logic signed [31:0] in_order_a,
  input  logic signed [31:0] in_point_x,
  input  logic [5:0]         in_deriv_order,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic               out_overflow
);
  import gpe_pkg::*;

  localparam int IW = $clog2(MAX_DEGREE + 2);
  localparam int CW = (IW > 6) ? IW : 6;

  st_t                state_r, state_nxt;
  logic               wait_r, wait_nxt;
  logic [IW-1:0]      m_r, m_nxt, k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic signed [63:0] a_r, a_nxt, x_r, x_nxt, ak_r, ak_nxt, g_r, g_nxt;
  logic signed [63:0] c0_r, c0_nxt, c1_r, c1_nxt, ck_r, ck_nxt;
  logic signed [63:0] xp_r, xp_nxt, t1_r, t1_nxt, dn_r, dn_nxt;
  logic signed [63:0] sc_r, sc_nxt, val_r, val_nxt;
  logic               ovf_r, ovf_nxt;

  mul_req_t           mreq;
  mul_rsp_t           mrsp;
  logic               m_start;
  sh_t                m_sh;
  logic signed [63:0] m_a, m_b, m_res;
  logic               d_start, d_done;
  logic signed [63:0] d_quo;

  logic [CW-1:0]      n_c, k_c;
  logic signed [63:0] p_v, q_v, f_v;
  logic [64:0]        diff;

  gpe_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mreq),
    .op_a   (m_a),
    .op_b   (m_b),
    .rsp    (mrsp),
    .result (m_res)
  );

  gpe_div #(.DW(IW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (d_start),
    .num   (dn_r),
    .den   (i_r),
    .done  (d_done),
    .quo   (d_quo)
  );

  assign mreq = '{start: m_start, sh: m_sh};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
    m_r   <= m_nxt;
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    a_r   <= a_nxt;
    x_r   <= x_nxt;
    ak_r  <= ak_nxt;
    g_r   <= g_nxt;
    c0_r  <= c0_nxt;
    c1_r  <= c1_nxt;
    ck_r  <= ck_nxt;
    xp_r  <= xp_nxt;
    t1_r  <= t1_nxt;
    dn_r  <= dn_nxt;
    sc_r  <= sc_nxt;
    val_r <= val_nxt;
    ovf_r <= ovf_nxt;
  end

  always_comb begin
    p_v = (64'(i_r) << 17) + g_r;
    q_v = (64'(i_r) << 16) + g_r;
    f_v = (a_r + (64'(j_r) << 16)) <<< 1;
    n_c = (CW'(in_degree) > CW'(MAX_DEGREE)) ? CW'(MAX_DEGREE) : CW'(in_degree);
    k_c = CW'(in_deriv_order);
    diff = {t1_r[63], t1_r} - {m_res[63], m_res};
  end

  // operand selection for the shared multiplier
  always_comb begin
    m_a  = sc_r;
    m_b  = ck_r;
    m_sh = SH_32;
    unique case (state_r)
      ST_C1: begin
        m_a = ak_r <<< 1;  m_b = x_r;  m_sh = SH_14;
      end
      ST_XP: begin
        m_a = x_r;  m_b = p_v;  m_sh = SH_14;
      end
      ST_T1: begin
        m_a = xp_r;  m_b = c1_r;  m_sh = SH_32;
      end
      ST_T2: begin
        m_a = q_v;  m_b = c0_r;  m_sh = SH_16;
      end
      ST_SC: begin
        m_a = sc_r;  m_b = f_v;  m_sh = SH_16;
      end
      default: begin
        m_a = sc_r;  m_b = ck_r;  m_sh = SH_32;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    wait_nxt   = wait_r;
    m_nxt = m_r;  k_nxt = k_r;  i_nxt = i_r;  j_nxt = j_r;
    a_nxt = a_r;  x_nxt = x_r;  ak_nxt = ak_r;  g_nxt = g_r;
    c0_nxt = c0_r;  c1_nxt = c1_r;  ck_nxt = ck_r;
    xp_nxt = xp_r;  t1_nxt = t1_r;  dn_nxt = dn_r;
    sc_nxt = sc_r;  val_nxt = val_r;  ovf_nxt = ovf_r;
    m_start = 1'b0;
    d_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt   = 64'(in_order_a);
          x_nxt   = 64'(in_point_x);
          ovf_nxt = 1'b0;
          wait_nxt = 1'b0;
          if (k_c > n_c) begin
            val_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            k_nxt     = k_c[IW-1:0];
            m_nxt     = IW'(n_c - k_c);
            ak_nxt    = 64'(in_order_a) + (64'(k_c) << 16);
            state_nxt = ST_C1;
          end
        end
      end
      ST_C1, ST_XP, ST_T1, ST_T2, ST_SC, ST_RES: begin
        if (!wait_r) begin
          m_start  = 1'b1;
          wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          wait_nxt = 1'b0;
          ovf_nxt  = ovf_r | mrsp.ovf;
          unique case (state_r)
            ST_C1: begin
              g_nxt  = (ak_r - ONE_Q16) <<< 1;
              c0_nxt = ONE_Q32;
              c1_nxt = m_res;
              ck_nxt = (m_r == '0) ? ONE_Q32 : m_res;
              i_nxt  = IW'(2);
              j_nxt  = '0;
              sc_nxt = ONE_Q32;
              if (m_r >= IW'(2))   state_nxt = ST_XP;
              else if (k_r != '0) state_nxt = ST_SC;
              else                state_nxt = ST_RES;
            end
            ST_XP: begin
              xp_nxt    = m_res;
              state_nxt = ST_T1;
            end
            ST_T1: begin
              t1_nxt    = m_res;
              state_nxt = ST_T2;
            end
            ST_T2: begin
              // saturating t1 - t2
              if (diff[64] != diff[63]) begin
                ovf_nxt = 1'b1;
                dn_nxt  = diff[64] ? SAT_MIN : SAT_MAX;
              end else begin
                dn_nxt  = diff[63:0];
              end
              state_nxt = ST_DIV;
            end
            ST_SC: begin
              sc_nxt = m_res;
              j_nxt  = j_r + IW'(1);
              if (j_r + IW'(1) >= k_r) state_nxt = ST_RES;
            end
            default: begin
              val_nxt   = m_res;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (!wait_r) begin
          d_start  = 1'b1;
          wait_nxt = 1'b1;
        end else if (d_done) begin
          wait_nxt = 1'b0;
          c0_nxt   = c1_r;
          c1_nxt   = d_quo;
          ck_nxt   = d_quo;
          i_nxt    = i_r + IW'(1);
          if (i_r + IW'(1) <= m_r) state_nxt = ST_XP;
          else if (k_r != '0)     state_nxt = ST_SC;
          else                    state_nxt = ST_RES;
        end
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = (state_r == ST_OUT);
  assign out_value    = val_r;
  assign out_overflow = ovf_r;

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result shown while input open");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> wait_r)
    else $error("multiplier result without a request");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    d_done |-> (wait_r && state_r == ST_DIV))
    else $error("divider result outside the divide step");

  a_start_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.start && d_start))
    else $error("both units started at once");

endmodule

// File: hw/rtl/gpe_mul.sv
`timescale 1ns / 1ps
module gpe_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  gpe_pkg::mul_req_t   req,
  input  logic signed [63:0]  op_a,
  input  logic signed [63:0]  op_b,
  output gpe_pkg::mul_rsp_t   rsp,
  output logic signed [63:0]  result
);
  import gpe_pkg::*;

  mphase_t            phase_r, phase_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [63:0]        ua_r, ua_nxt, ub_r, ub_nxt;
  logic               neg_r, neg_nxt;
  sh_t                sh_r, sh_nxt;
  logic [127:0]       acc_r, acc_nxt;
  logic signed [63:0] res_r, res_nxt;
  logic               done_r, done_nxt;
  logic               ovf_r, ovf_nxt;

  logic [31:0]  a_sel, b_sel;
  logic [63:0]  pp;
  logic [127:0] pp_pos, rnd;
  logic         hi_nz;
  logic [63:0]  mlo, limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    ua_r  <= ua_nxt;
    ub_r  <= ub_nxt;
    neg_r <= neg_nxt;
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    ovf_r <= ovf_nxt;
  end

  // one 32x32 partial product per cycle
  always_comb begin
    a_sel = cnt_r[0] ? ua_r[63:32] : ua_r[31:0];
    b_sel = cnt_r[1] ? ub_r[63:32] : ub_r[31:0];
    pp    = 64'(a_sel) * 64'(b_sel);
    case (cnt_r)
      2'd0:    pp_pos = 128'(pp);
      2'd3:    pp_pos = 128'(pp) << 64;
      default: pp_pos = 128'(pp) << 32;
    endcase
    unique case (sh_r)
      SH_14: begin
        rnd   = 128'(1) << 13;
        hi_nz = |acc_r[127:78];
        mlo   = acc_r[77:14];
      end
      SH_16: begin
        rnd   = 128'(1) << 15;
        hi_nz = |acc_r[127:80];
        mlo   = acc_r[79:16];
      end
      default: begin
        rnd   = 128'(1) << 31;
        hi_nz = |acc_r[127:96];
        mlo   = acc_r[95:32];
      end
    endcase
    limit = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ua_nxt    = ua_r;
    ub_nxt    = ub_r;
    neg_nxt   = neg_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      M_IDLE: begin
        if (req.start) begin
          ua_nxt    = op_a[63] ? 64'(0) - op_a : op_a;
          ub_nxt    = op_b[63] ? 64'(0) - op_b : op_b;
          neg_nxt   = op_a[63] ^ op_b[63];
          sh_nxt    = req.sh;
          acc_nxt   = '0;
          cnt_nxt   = 2'd0;
          phase_nxt = M_ACC;
        end
      end
      M_ACC: begin
        acc_nxt = acc_r + pp_pos;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) phase_nxt = M_RND;
      end
      M_RND: begin
        acc_nxt   = acc_r + rnd;
        phase_nxt = M_FIN;
      end
      M_FIN: begin
        done_nxt  = 1'b1;
        phase_nxt = M_IDLE;
        if (hi_nz || mlo > limit) begin
          ovf_nxt = 1'b1;
          res_nxt = neg_r ? SAT_MIN : SAT_MAX;
        end else begin
          ovf_nxt = 1'b0;
          res_nxt = neg_r ? 64'(0) - mlo : mlo;
        end
      end
      default: phase_nxt = M_IDLE;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign result   = res_r;

endmodule

// File: hw/rtl/gpe_div.sv
`timescale 1ns / 1ps
module gpe_div #(
  parameter int DW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [63:0]  num,
  input  logic [DW-1:0]       den,
  output logic                done,
  output logic signed [63:0]  quo
);
  import gpe_pkg::*;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [63:0]   dvd_r, dvd_nxt, q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [63:0]   res_r, res_nxt;

  logic [DW:0]   rem_v;
  logic [63:0]   dvd_v, q_v, mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  // eight quotient bits per cycle, remainder stays below the divisor
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    rem_v    = {1'b0, rem_r};
    dvd_v    = dvd_r;
    q_v      = q_r;
    mag      = num[63] ? 64'(0) - num : num;
    if (!busy_r) begin
      if (start) begin
        dvd_nxt  = mag + 64'(den >> 1);
        rem_nxt  = '0;
        q_nxt    = '0;
        den_nxt  = den;
        neg_nxt  = num[63];
        cnt_nxt  = 3'd0;
        busy_nxt = 1'b1;
      end
    end else begin
      for (int b = 0; b < 8; b++) begin
        rem_v = {rem_v[DW-1:0], dvd_v[63]};
        dvd_v = dvd_v << 1;
        if (rem_v >= {1'b0, den_r}) begin
          rem_v = rem_v - {1'b0, den_r};
          q_v   = {q_v[62:0], 1'b1};
        end else begin
          q_v   = {q_v[62:0], 1'b0};
        end
      end
      rem_nxt = rem_v[DW-1:0];
      dvd_nxt = dvd_v;
      q_nxt   = q_v;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? 64'(0) - q_v : q_v;
      end
    end
  end

  assign done = done_r;
  assign quo  = res_r;

endmodule
